// ===== src/tbhld_pkg.sv =====
// ============================================================================
// tbhld_pkg: shared types and constants for the two-byte-header deframer
// Word layouts, configuration register indexes and reset values.
// ============================================================================
package tbhld_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 9;
    localparam int unsigned CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_HEADER  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_HEADER = 1'b1;

    // Header register values after reset.
    localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'h5A;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'hA5;

    // The length slot holds L plus the two headers plus the length byte itself.
    localparam logic [INDEX_W-1:0] LENGTH_BIAS = 9'd3;

    // Position of the length byte within a frame.
    localparam logic [INDEX_W-1:0] LENGTH_SLOT = 9'd2;

    // Input command codes.
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
        logic              burst_end;
    } t_in_word;

    typedef struct packed {
        logic               accepted;
        logic               stored;
        logic [INDEX_W-1:0] byte_index;
        logic [BYTE_W-1:0]  stored_value;
        logic               frame_done;
        logic               burst_end_echo;
    } t_result;

endpackage

// ===== src/tbhld_in_reg.sv =====
// ============================================================================
// tbhld_in_reg: input word register
// Captures one incoming word and holds it until the framing logic takes it.
// ============================================================================
module tbhld_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tbhld_pkg::t_in_word i_word,
    input  logic               i_advance,
    output logic               o_ready,
    output logic               o_valid,
    output tbhld_pkg::t_in_word o_word
);
    import tbhld_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // The register can take a new word when empty or when its word moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== src/tbhld_core.sv =====
// ============================================================================
// tbhld_core: frame synchronizer state and result logic
// Holds the header registers and hunt state and forms one result per word.
// ============================================================================
module tbhld_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tbhld_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tbhld_pkg::BYTE_W-1:0]      i_cfg_data,
    input  logic                             i_advance,
    input  tbhld_pkg::t_in_word               i_word,
    output tbhld_pkg::t_result                o_result
);
    import tbhld_pkg::*;

    logic [BYTE_W-1:0]  r_first_header;
    logic [BYTE_W-1:0]  r_second_header;
    logic               r_first_seen;
    logic               r_second_seen;
    logic [INDEX_W-1:0] r_count;
    logic [INDEX_W-1:0] r_total;
    logic               r_held;

    logic               n_first_seen;
    logic               n_second_seen;
    logic [INDEX_W-1:0] n_count;
    logic [INDEX_W-1:0] n_total;
    logic               n_held;
    logic [INDEX_W-1:0] count_inc;
    logic [INDEX_W-1:0] length_total;
    t_result            result;

    assign count_inc    = r_count + INDEX_W'(1);
    assign length_total = {1'b0, i_word.data_byte} + LENGTH_BIAS;

    always_comb begin
        n_first_seen  = r_first_seen;
        n_second_seen = r_second_seen;
        n_count       = r_count;
        n_total       = r_total;
        n_held        = r_held;
        result        = '0;
        result.burst_end_echo = i_word.burst_end;

        if (i_word.command == CMD_RELEASE) begin
            n_held = 1'b0;
        end else if (!r_held) begin
            result.accepted = 1'b1;
            if (!r_first_seen) begin
                if (i_word.data_byte == r_first_header) begin
                    result.stored       = 1'b1;
                    result.byte_index   = r_count;
                    result.stored_value = i_word.data_byte;
                    n_count             = count_inc;
                    n_first_seen        = 1'b1;
                end else begin
                    n_count = '0;
                end
            end else if (!r_second_seen) begin
                // A failed second header is dropped, not retried as a first header.
                if (i_word.data_byte == r_second_header) begin
                    result.stored       = 1'b1;
                    result.byte_index   = r_count;
                    result.stored_value = i_word.data_byte;
                    n_count             = count_inc;
                    n_second_seen       = 1'b1;
                end else begin
                    n_count       = '0;
                    n_first_seen  = 1'b0;
                    n_second_seen = 1'b0;
                end
            end else if (r_count == LENGTH_SLOT) begin
                n_total             = length_total;
                result.stored       = 1'b1;
                result.byte_index   = r_count;
                result.stored_value = length_total[BYTE_W-1:0];
                n_count             = count_inc;
            end else begin
                result.stored       = 1'b1;
                result.byte_index   = r_count;
                result.stored_value = i_word.data_byte;
                n_count             = count_inc;
                if (count_inc > r_total) begin
                    result.frame_done = 1'b1;
                    n_count           = '0;
                    n_first_seen      = 1'b0;
                    n_second_seen     = 1'b0;
                    n_held            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_header  <= FIRST_HEADER_RST;
            r_second_header <= SECOND_HEADER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_HEADER:  r_first_header  <= i_cfg_data;
                CFG_SECOND_HEADER: r_second_header <= i_cfg_data;
                default:           r_first_header  <= r_first_header;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_seen  <= 1'b0;
            r_second_seen <= 1'b0;
            r_count       <= '0;
            r_total       <= '0;
            r_held        <= 1'b0;
        end else if (i_advance) begin
            r_first_seen  <= n_first_seen;
            r_second_seen <= n_second_seen;
            r_count       <= n_count;
            r_total       <= n_total;
            r_held        <= n_held;
        end
    end

    assign o_result = result;

endmodule

// ===== src/tbhld_out_reg.sv =====
// ============================================================================
// tbhld_out_reg: result register
// Holds one finished result until the downstream side takes it.
// ============================================================================
module tbhld_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tbhld_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output tbhld_pkg::t_result o_result
);
    import tbhld_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== src/two_byte_header_length_deframer.sv =====
// ============================================================================
// two_byte_header_length_deframer: length-prefixed frame synchronizer
// Finds two header bytes, reads a length byte and tags each frame byte.
// ============================================================================
// The block takes one received byte per word and returns exactly one result
// word for each. It hunts for the first header byte followed directly by the
// second header byte; a wrong second header is dropped and the hunt restarts
// without testing that byte as a first header. The next byte is a length L,
// reported in its slot as (L+3) mod 256, followed by L data bytes and one
// checksum byte that is passed on unchecked. Every kept byte is reported with
// its position in the frame, and the byte at position L+3 flags frame_done.
// After that, data bytes are refused (accepted is 0) until a release command
// word arrives. A word is accepted while the input register is empty or its
// held word moves on to the result register: it passes an input register,
// then the header compare and position counter update, then a result
// register, which presents it on the master side. The sustained rate is one
// word per clock while the output is taken. Header values are to be written
// through the configuration port only while the block is idle; the block
// does not enforce this. Register 0 is the first header and register 1 the
// second.
// ============================================================================
module two_byte_header_length_deframer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [tbhld_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tbhld_pkg::BYTE_W-1:0]      i_cfg_data,
    // Slave side: received bytes and release commands.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] data_byte
    input  logic                              s_tuser,  // [0] command
    input  logic                              s_tlast,  // burst_end
    // Master side: one result per input word.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // [8:0] byte_index,
                                                        // [16:9] stored_value,
                                                        // [23:17] zero
    output logic [2:0]                        m_tuser,  // [0] accepted,
                                                        // [1] stored,
                                                        // [2] frame_done
    output logic                              m_tlast   // burst_end_echo
);
    import tbhld_pkg::*;

    t_in_word in_word;
    t_in_word held_word;
    logic     held_valid;
    logic     can_load;
    logic     advance;
    t_result  core_result;
    t_result  out_result;

    assign in_word.command   = s_tuser;
    assign in_word.data_byte = s_tdata;
    assign in_word.burst_end = s_tlast;

    // A held word moves on, updating the framing state, whenever the result
    // register has room for its result.
    assign advance = held_valid && can_load;

    tbhld_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .i_word    (in_word),
        .i_advance (advance),
        .o_ready   (s_tready),
        .o_valid   (held_valid),
        .o_word    (held_word)
    );

    tbhld_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (advance),
        .i_word      (held_word),
        .o_result    (core_result)
    );

    tbhld_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (core_result),
        .i_ready    (m_tready),
        .o_can_load (can_load),
        .o_valid    (m_tvalid),
        .o_result   (out_result)
    );

    assign m_tdata = {7'd0, out_result.stored_value, out_result.byte_index};
    assign m_tuser = {out_result.frame_done, out_result.stored, out_result.accepted};
    assign m_tlast = out_result.burst_end_echo;

endmodule

// ===== bench/two_byte_header_length_deframer_checker.sv =====
// ============================================================================
// two_byte_header_length_deframer_checker: result checker for the deframer
// Tracks header register writes and accepted input words, predicts the result
// of each word and compares it with the words leaving the master side.
// ============================================================================
`timescale 1ns / 1ps

module two_byte_header_length_deframer_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tbhld_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tbhld_pkg::BYTE_W-1:0]      i_cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] data_byte
    input  logic                              s_tuser,  // [0] command
    input  logic                              s_tlast,  // burst_end
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [23:0]                       m_tdata,  // [8:0] byte_index,
                                                        // [16:9] stored_value
    input  logic [2:0]                        m_tuser,  // [0] accepted, [1] stored,
                                                        // [2] frame_done
    input  logic                              m_tlast,  // burst_end_echo
    output int                                o_fail_count,
    output int                                o_pending
);
    import tbhld_pkg::*;

    localparam int PRINT_LIMIT = 25;

    // Mirror of the header registers and of the frame hunt state.
    logic [BYTE_W-1:0]  first_hdr;
    logic [BYTE_W-1:0]  second_hdr;
    logic               hdr1_seen;
    logic               hdr2_seen;
    logic               frame_held;
    logic [INDEX_W-1:0] frame_pos;
    logic [INDEX_W-1:0] frame_last;

    t_result expected_results[$];
    int      fail_count = 0;
    int      result_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t: result %0d: %s is %0d, expected %0d",
                     $realtime, result_count, what, got, want);
        end
        fail_count++;
    endtask

    // Advances the frame state by one input word and returns its result.
    function automatic t_result deframe_step(input t_in_word w);
        t_result r;
        r = '0;
        r.burst_end_echo = w.burst_end;
        if (w.command == CMD_RELEASE) begin
            frame_held = 1'b0;
        end else if (!frame_held) begin
            r.accepted = 1'b1;
            if (!hdr1_seen) begin
                if (w.data_byte == first_hdr) begin
                    r.stored       = 1'b1;
                    r.byte_index   = frame_pos;
                    r.stored_value = w.data_byte;
                    frame_pos      = frame_pos + INDEX_W'(1);
                    hdr1_seen      = 1'b1;
                end else begin
                    frame_pos = '0;
                end
            end else if (!hdr2_seen) begin
                if (w.data_byte == second_hdr) begin
                    r.stored       = 1'b1;
                    r.byte_index   = frame_pos;
                    r.stored_value = w.data_byte;
                    frame_pos      = frame_pos + INDEX_W'(1);
                    hdr2_seen      = 1'b1;
                end else begin
                    // The byte is dropped; it is not tried as a first header.
                    frame_pos = '0;
                    hdr1_seen = 1'b0;
                    hdr2_seen = 1'b0;
                end
            end else if (frame_pos == LENGTH_SLOT) begin
                frame_last     = {1'b0, w.data_byte} + LENGTH_BIAS;
                r.stored       = 1'b1;
                r.byte_index   = frame_pos;
                r.stored_value = frame_last[BYTE_W-1:0];
                frame_pos      = frame_pos + INDEX_W'(1);
            end else begin
                r.stored       = 1'b1;
                r.byte_index   = frame_pos;
                r.stored_value = w.data_byte;
                frame_pos      = frame_pos + INDEX_W'(1);
                if (frame_pos > frame_last) begin
                    r.frame_done = 1'b1;
                    frame_pos    = '0;
                    hdr1_seen    = 1'b0;
                    hdr2_seen    = 1'b0;
                    frame_held   = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_in_word w;
        t_result  got;
        t_result  want;
        if (!i_rst_n) begin
            first_hdr  = FIRST_HEADER_RST;
            second_hdr = SECOND_HEADER_RST;
            hdr1_seen  = 1'b0;
            hdr2_seen  = 1'b0;
            frame_held = 1'b0;
            frame_pos  = '0;
            frame_last = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_HEADER:  first_hdr  = i_cfg_data;
                    CFG_SECOND_HEADER: second_hdr = i_cfg_data;
                    default: ;
                endcase
            end
            // The input side is handled first so that a result leaving in the same cycle
            // as its word is accepted would still find its expectation.
            if (s_tvalid && s_tready) begin
                w.command   = s_tuser;
                w.data_byte = s_tdata;
                w.burst_end = s_tlast;
                expected_results.push_back(deframe_step(w));
            end
            if (m_tvalid && m_tready) begin
                got.accepted       = m_tuser[0];
                got.stored         = m_tuser[1];
                got.frame_done     = m_tuser[2];
                got.byte_index     = m_tdata[8:0];
                got.stored_value   = m_tdata[16:9];
                got.burst_end_echo = m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result word, pending count", 0, 1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted != want.accepted)
                        report_mismatch("accepted", int'(got.accepted),
                                        int'(want.accepted));
                    if (got.stored != want.stored)
                        report_mismatch("stored", int'(got.stored), int'(want.stored));
                    if (got.byte_index != want.byte_index)
                        report_mismatch("byte_index", int'(got.byte_index),
                                        int'(want.byte_index));
                    if (got.stored_value != want.stored_value)
                        report_mismatch("stored_value", int'(got.stored_value),
                                        int'(want.stored_value));
                    if (got.frame_done != want.frame_done)
                        report_mismatch("frame_done", int'(got.frame_done),
                                        int'(want.frame_done));
                    if (got.burst_end_echo != want.burst_end_echo)
                        report_mismatch("burst_end_echo", int'(got.burst_end_echo),
                                        int'(want.burst_end_echo));
                end
                result_count++;
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== bench/two_byte_header_length_deframer_tb.sv =====
// ============================================================================
// two_byte_header_length_deframer_tb: top-level bench for the deframer
// Drives byte and release words with random idle gaps and receiver stalls,
// across several header settings; a checker predicts and compares results.
// ============================================================================
`timescale 1ns / 1ps

module two_byte_header_length_deframer_tb;
    import tbhld_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RESET_CYCLES    = 10;
    localparam int WORDS_PER_PHASE = 30;
    // Long enough for the block and its output stage to fill completely.
    localparam int PRESSURE_HOLD   = 200;
    // Results pass the input and result registers; leave a comfortable margin.
    localparam int DRAIN_CYCLES    = 16;

    // Receiver behavior for one stretch of cycles.
    localparam int RX_STREAM = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_STALL  = 2;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_FIRST_HEADER;
    logic [BYTE_W-1:0]      i_cfg_data  = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata     = '0;  // [7:0] data_byte
    logic                   s_tuser     = CMD_DATA;  // [0] command
    logic                   s_tlast     = 1'b0;  // burst_end
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [23:0]            m_tdata;  // [8:0] byte_index, [16:9] stored_value, [23:17] zero
    logic [2:0]             m_tuser;  // [0] accepted, [1] stored, [2] frame_done
    logic                   m_tlast;  // burst_end_echo

    int fail_count;
    int pending;

    // Header values currently programmed, used to build well-formed frames.
    logic [BYTE_W-1:0] cur_first  = FIRST_HEADER_RST;
    logic [BYTE_W-1:0] cur_second = SECOND_HEADER_RST;

    // Sender idle control: while calm_left is nonzero no gaps are inserted.
    int calm_left = 0;
    int data_words = 0;

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_requested = 1'b0;
    bit hold_served    = 1'b0;

    always #4 i_clk = ~i_clk;

    two_byte_header_length_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    two_byte_header_length_deframer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic rand_last();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly back-to-back words, some short gaps and a few long ones, with
    // occasional calm stretches that have no gaps at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 2) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one word and holds it until the block takes it. Valid stays high
    // into the next word unless a gap is chosen.
    task automatic send_word(input logic cmd, input logic [7:0] data_byte, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data_byte;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (cmd == CMD_DATA) data_words++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Writes both header registers, the first header and then the second.
    task automatic set_headers(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FIRST_HEADER;
        i_cfg_data  <= first;
        @(posedge i_clk);
        i_cfg_index <= CFG_SECOND_HEADER;
        i_cfg_data  <= second;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        cur_first  = first;
        cur_second = second;
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One complete frame: both headers, the length, the payload and the
    // checksum. Afterward a few bytes may be sent into the held frame, and
    // the frame is usually released.
    task automatic send_frame(input int unsigned len, input bit with_release);
        send_word(CMD_DATA, cur_first, rand_last());
        send_word(CMD_DATA, cur_second, rand_last());
        send_word(CMD_DATA, 8'(len), rand_last());
        repeat (len) send_word(CMD_DATA, 8'($urandom), rand_last());
        send_word(CMD_DATA, 8'($urandom), rand_last());
        repeat ($urandom_range(0, 2)) send_word(CMD_DATA, 8'($urandom), rand_last());
        if (with_release) send_word(CMD_RELEASE, 8'($urandom), rand_last());
    endtask

    // Stray bytes, stray releases and broken header sequences.
    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: send_word(CMD_DATA, 8'($urandom), rand_last());
            1: send_word(CMD_RELEASE, 8'($urandom), rand_last());
            2: begin
                send_word(CMD_DATA, cur_first, rand_last());
                send_word(CMD_DATA, 8'($urandom), rand_last());
            end
            3: begin
                // A repeated first header fails as a second header and is
                // not taken as a new first header.
                send_word(CMD_DATA, cur_first, rand_last());
                send_word(CMD_DATA, cur_first, rand_last());
                send_word(CMD_DATA, cur_second, rand_last());
            end
            4: begin
                send_word(CMD_DATA, cur_first, rand_last());
                send_word(CMD_DATA, ~cur_second, rand_last());
            end
            default: repeat ($urandom_range(1, 4)) send_word(CMD_DATA, 8'($urandom), rand_last());
        endcase
    endtask

    // Mostly short frames, some medium ones and rarely a near-maximum one.
    function automatic int unsigned pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 12);
        if (r < 98) return $urandom_range(13, 40);
        return $urandom_range(200, 255);
    endfunction

    task automatic random_phase(input int words);
        int target;
        target = data_words + words;
        while (data_words < target) begin
            if ($urandom_range(0, 99) < 75) begin
                send_frame(pick_length(), $urandom_range(0, 9) != 0);
            end else begin
                send_noise();
            end
        end
    endtask

    // Receiver: stretches of steady, choppy or stalled readiness, plus one
    // long hold-off when the stimulus asks for it.
    initial begin : receiver
        int span_left;
        int mode;
        int hold_left;
        int r;
        span_left = 0;
        mode      = RX_STREAM;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requested && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (span_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 50) begin
                        mode      = RX_STREAM;
                        span_left = $urandom_range(5, 40);
                    end else if (r < 90) begin
                        mode      = RX_CHOPPY;
                        span_left = $urandom_range(5, 40);
                    end else begin
                        mode      = RX_STALL;
                        span_left = $urandom_range(10, 60);
                    end
                end
                span_left--;
                case (mode)
                    RX_STREAM: m_tready <= 1'b1;
                    RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= 1'b0;
                endcase
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[two_byte_header_length_deframer] ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: the reset header values, written explicitly.
        set_headers(FIRST_HEADER_RST, SECOND_HEADER_RST);

        // A release with no frame held has no effect.
        send_word(CMD_RELEASE, 8'hFF, 1'b1);
        // A byte that is not a first header is dropped.
        send_word(CMD_DATA, 8'h00, 1'b0);
        // A wrong second header is dropped and not retried as a first header,
        // so the following second-header value is dropped as well.
        send_word(CMD_DATA, cur_first, 1'b0);
        send_word(CMD_DATA, cur_first, 1'b1);
        send_word(CMD_DATA, cur_second, 1'b0);
        // Shortest frame: zero length, checksum only.
        send_word(CMD_DATA, cur_first, 1'b0);
        send_word(CMD_DATA, cur_second, 1'b0);
        send_word(CMD_DATA, 8'h00, 1'b0);
        send_word(CMD_DATA, 8'hFF, 1'b1);
        // The frame is held: bytes are refused until the release.
        send_word(CMD_DATA, cur_first, 1'b1);
        send_word(CMD_DATA, 8'hFF, 1'b0);
        send_word(CMD_RELEASE, 8'h00, 1'b0);
        send_word(CMD_RELEASE, 8'hFF, 1'b1);
        // One-byte payload.
        send_word(CMD_DATA, cur_first, 1'b1);
        send_word(CMD_DATA, cur_second, 1'b1);
        send_word(CMD_DATA, 8'h01, 1'b1);
        send_word(CMD_DATA, 8'hAA, 1'b0);
        send_word(CMD_DATA, 8'h55, 1'b1);
        send_word(CMD_RELEASE, 8'h00, 1'b0);

        // A length whose slot value wraps to zero and whose final index
        // passes 255.
        send_frame(253, 1'b1);

        random_phase(WORDS_PER_PHASE);
        wait_idle();

        // Phase two: extreme header values, with the long receiver hold-off.
        set_headers(8'h00, 8'hFF);
        hold_requested = 1'b1;
        calm_left      = 60;
        send_frame(20, 1'b1);
        send_frame(20, 1'b1);
        random_phase(WORDS_PER_PHASE);
        wait_idle();

        // Phase three: the opposite extremes.
        set_headers(8'hFF, 8'h00);
        random_phase(WORDS_PER_PHASE);
        wait_idle();

        // Phase four: both headers equal, so a repeated header byte matches.
        set_headers(8'h33, 8'h33);
        random_phase(WORDS_PER_PHASE);
        wait_idle();

        // Phase five: arbitrary header values.
        set_headers(8'($urandom), 8'($urandom));
        random_phase(WORDS_PER_PHASE);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[two_byte_header_length_deframer] OK");
        end else begin
            $display("[two_byte_header_length_deframer] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tbhld_pkg.sv
src/tbhld_in_reg.sv
src/tbhld_core.sv
src/tbhld_out_reg.sv
src/two_byte_header_length_deframer.sv
bench/two_byte_header_length_deframer_checker.sv
bench/two_byte_header_length_deframer_tb.sv
